@@ rtl/core/sclp_pkg.sv @@
// Shared types and constants for the serial command line parser.
// No dependencies; used by sclp_line_parser and serial_command_line_parser.
`timescale 1ns / 1ps

package sclp_pkg;

    localparam logic [7:0] BYTE_CR    = 8'd13;
    localparam logic [7:0] BYTE_SPACE = 8'd32;
    localparam logic [7:0] BYTE_TAB   = 8'd9;
    localparam logic [7:0] BYTE_FF    = 8'd12;
    localparam logic [7:0] BYTE_PLUS  = 8'h2B;
    localparam logic [7:0] BYTE_MINUS = 8'h2D;
    localparam logic [7:0] BYTE_ZERO  = 8'h30;
    localparam logic [7:0] BYTE_NINE  = 8'h39;

    localparam logic [31:0] MAG_LIMIT  = 32'h8000_0000;
    localparam logic [31:0] POS_MAX    = 32'h7FFF_FFFF;

    typedef enum logic [1:0] {
        FIELD_LETTER = 2'd0,
        FIELD_FIRST  = 2'd1,
        FIELD_SECOND = 2'd2
    } t_field_pos;

    typedef enum logic [1:0] {
        PHASE_SKIP    = 2'd0,
        PHASE_DIGITS  = 2'd1,
        PHASE_STOPPED = 2'd2
    } t_number_phase;

    typedef struct packed {
        logic [7:0]         letter;
        logic signed [31:0] first_value;
        logic signed [31:0] second_value;
    } t_line_result;

    typedef struct packed {
        t_field_pos    field_pos;
        t_number_phase phase;
    } t_parse_status;

endpackage

@@ rtl/core/serial_command_line_parser.sv @@
// Serial command line parser: takes "letter arg1 arg2" lines ended by CR.
// A CR word moves from the input register into the result register, which drives the result outputs.
// Throughput: one byte word per cycle, except while a CR in the input register waits
// for room in the result register.
// Reset (synchronous, active low) clears field position, letter, values, flags.
// Depends on sclp_pkg and sclp_line_parser.
`timescale 1ns / 1ps

module serial_command_line_parser #(
    parameter int FIELD_BUFFER_BYTES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_rx_byte,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [7:0]         o_command_letter,
    output logic signed [31:0] o_first_value,
    output logic signed [31:0] o_second_value
);

    // Input register: holds one byte word ahead of the parser.
    logic       r_in_valid, n_in_valid;
    logic [7:0] r_in_byte;

    // Result register.
    logic                   r_out_valid, n_out_valid;
    sclp_pkg::t_line_result r_result;

    sclp_pkg::t_line_result  w_result;
    sclp_pkg::t_parse_status w_status;

    logic w_out_free;
    logic w_is_cr;
    logic w_advance;
    logic w_in_take;
    logic w_emit;

    // The result register is free when empty or when its word leaves now.
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_is_cr    = (r_in_byte == sclp_pkg::BYTE_CR);
    // Non-CR bytes never produce a word, so they always advance; a CR waits
    // for room in the result register.
    assign w_advance  = r_in_valid && (!w_is_cr || w_out_free);
    assign w_emit     = w_advance && w_is_cr;
    assign o_in_stall = r_in_valid && !w_advance;
    assign w_in_take  = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_in_take) begin
            n_in_valid = 1'b1;
        end else if (w_advance) begin
            n_in_valid = 1'b0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_emit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    sclp_line_parser #(
        .FIELD_BUFFER_BYTES(FIELD_BUFFER_BYTES)
    ) u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_take   (w_advance),
        .i_byte   (r_in_byte),
        .o_result (w_result),
        .o_status (w_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers: the input byte loads on take, the result on emit; both hold otherwise.
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_byte <= i_rx_byte;
        end
        if (w_emit) begin
            r_result <= w_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_command_letter = r_result.letter;
    assign o_first_value    = r_result.first_value;
    assign o_second_value   = r_result.second_value;

    // A new result word only appears after a CR went through the parser.
    a_out_from_cr : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_emit))
        else $error("result word without CR");

    // An emitted CR always lands in the result register.
    a_emit_lands : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> r_out_valid)
        else $error("CR result lost");

    // After a CR the parser is back in the letter field, skipping whitespace.
    a_cr_clears : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit |=> (w_status.field_pos == sclp_pkg::FIELD_LETTER &&
                    w_status.phase == sclp_pkg::PHASE_SKIP))
        else $error("parser state not cleared on CR");

    // Input stalls only while the input register holds a CR blocked downstream.
    a_stall_cause : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && w_is_cr && r_out_valid && i_out_stall))
        else $error("input stalled without cause");

endmodule

@@ rtl/core/sclp_line_parser.sv @@
// Line parser state: letter field, field position and atoi-style conversion.
// Depends on sclp_pkg.
`timescale 1ns / 1ps

module sclp_line_parser #(
    parameter int FIELD_BUFFER_BYTES = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_take,
    input  logic [7:0]              i_byte,
    output sclp_pkg::t_line_result  o_result,
    output sclp_pkg::t_parse_status o_status
);

    localparam int CW = (FIELD_BUFFER_BYTES > 2) ? $clog2(FIELD_BUFFER_BYTES) : 1;
    localparam logic [CW-1:0] CHAR_LIMIT = CW'(FIELD_BUFFER_BYTES - 1);

    sclp_pkg::t_field_pos    r_field_pos, n_field_pos;
    sclp_pkg::t_number_phase r_phase, n_phase;
    logic [CW-1:0]           r_char_count, n_char_count;
    logic [7:0]              r_letter, n_letter;
    logic [31:0]             r_first, n_first;
    logic [31:0]             r_mag, n_mag;
    logic                    r_neg, n_neg;

    logic [31:0] w_value;
    logic [35:0] w_mag_x10;
    logic        w_is_digit;
    logic        w_is_ws;

    // Signed value of the number under conversion, clipped on the positive side.
    always_comb begin
        if (r_neg) begin
            w_value = 32'd0 - r_mag;
        end else if (r_mag > sclp_pkg::POS_MAX) begin
            w_value = sclp_pkg::POS_MAX;
        end else begin
            w_value = r_mag;
        end
    end

    assign w_is_digit = (i_byte >= sclp_pkg::BYTE_ZERO) && (i_byte <= sclp_pkg::BYTE_NINE);
    assign w_is_ws    = (i_byte >= sclp_pkg::BYTE_TAB) && (i_byte <= sclp_pkg::BYTE_FF);
    assign w_mag_x10  = {1'b0, r_mag, 3'b000} + {3'b000, r_mag, 1'b0}
                      + {32'd0, i_byte[3:0] - sclp_pkg::BYTE_ZERO[3:0]};

    always_comb begin
        n_field_pos  = r_field_pos;
        n_phase      = r_phase;
        n_char_count = r_char_count;
        n_letter     = r_letter;
        n_first      = r_first;
        n_mag        = r_mag;
        n_neg        = r_neg;
        if (i_byte == sclp_pkg::BYTE_CR) begin
            n_field_pos  = sclp_pkg::FIELD_LETTER;
            n_phase      = sclp_pkg::PHASE_SKIP;
            n_char_count = '0;
            n_letter     = 8'd0;
            n_first      = 32'd0;
            n_mag        = 32'd0;
            n_neg        = 1'b0;
        end else if (i_byte == sclp_pkg::BYTE_SPACE) begin
            if (r_field_pos != sclp_pkg::FIELD_SECOND) begin
                if (r_field_pos == sclp_pkg::FIELD_FIRST) begin
                    n_first = w_value;
                    n_field_pos = sclp_pkg::FIELD_SECOND;
                end else begin
                    n_field_pos = sclp_pkg::FIELD_FIRST;
                end
                n_phase      = sclp_pkg::PHASE_SKIP;
                n_char_count = '0;
                n_mag        = 32'd0;
                n_neg        = 1'b0;
            end
        end else if (r_field_pos == sclp_pkg::FIELD_LETTER) begin
            n_letter = i_byte;
        end else if (r_char_count < CHAR_LIMIT) begin
            n_char_count = r_char_count + 1'b1;
            if (r_phase == sclp_pkg::PHASE_SKIP && w_is_ws) begin
                n_phase = r_phase;
            end else if (r_phase == sclp_pkg::PHASE_SKIP &&
                         (i_byte == sclp_pkg::BYTE_PLUS || i_byte == sclp_pkg::BYTE_MINUS)) begin
                n_neg   = (i_byte == sclp_pkg::BYTE_MINUS);
                n_phase = sclp_pkg::PHASE_DIGITS;
            end else if (r_phase != sclp_pkg::PHASE_STOPPED && w_is_digit) begin
                // Saturate the magnitude at 2^31.
                n_mag   = (w_mag_x10 > {4'd0, sclp_pkg::MAG_LIMIT}) ? sclp_pkg::MAG_LIMIT
                                                                    : w_mag_x10[31:0];
                n_phase = sclp_pkg::PHASE_DIGITS;
            end else begin
                n_phase = sclp_pkg::PHASE_STOPPED;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_pos  <= sclp_pkg::FIELD_LETTER;
            r_phase      <= sclp_pkg::PHASE_SKIP;
            r_char_count <= '0;
            r_letter     <= 8'd0;
            r_first      <= 32'd0;
            r_mag        <= 32'd0;
            r_neg        <= 1'b0;
        end else if (i_take) begin
            r_field_pos  <= n_field_pos;
            r_phase      <= n_phase;
            r_char_count <= n_char_count;
            r_letter     <= n_letter;
            r_first      <= n_first;
            r_mag        <= n_mag;
            r_neg        <= n_neg;
        end
    end

    // Result as a CR would emit it from the current state.
    always_comb begin
        o_result.letter       = r_letter;
        o_result.first_value  = 32'sd0;
        o_result.second_value = 32'sd0;
        case (r_field_pos)
            sclp_pkg::FIELD_FIRST: begin
                o_result.first_value = w_value;
            end
            sclp_pkg::FIELD_SECOND: begin
                o_result.first_value  = r_first;
                o_result.second_value = w_value;
            end
            default: begin
                o_result.first_value = 32'sd0;
            end
        endcase
    end

    assign o_status.field_pos = r_field_pos;
    assign o_status.phase     = r_phase;

endmodule
